/* src/spal_pkg.sv */
// Shared definitions for the slot pool with active list: pool size, field
// widths, request and status codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spal_pkg;

   localparam int POOL_SLOTS = 16;
   localparam int SLOT_W     = $clog2(POOL_SLOTS);
   localparam int COUNT_W    = $clog2(POOL_SLOTS + 1);
   localparam int HOUSE_W    = 3;
   localparam int REQ_W      = 3;
   localparam int STATUS_W   = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_ALLOC   = 3'd0,
      REQ_FREE    = 3'd1,
      REQ_FIND    = 3'd2,
      REQ_RECOUNT = 3'd3,
      REQ_CLEAR   = 3'd4
   } req_code_type;

   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NONE     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BUSY     = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_USED = 2'd3;

endpackage

`default_nettype wire

/* src/slot_pool_with_active_list.sv */
// Top level of the slot pool: used bits, owner houses, compacted active list
// and the sequencer that walks them. Depends on spal_pkg.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_ready | type, slot, any_slot, house,
//           |           |                       | any_house, cursor, from_start
//   rsp_    | out       | rsp_valid / rsp_ready | status, result_slot, position,
//           |           |                       | active_count
//
// One index counter and one compare path are shared by every request that
// scans, and step through the pool or the list at one entry per cycle. Clear
// and unknown types go straight to the done state. After each response the
// sequencer returns to idle before the next request is taken.
// Synchronous reset empties the pool at once.
// req_ready is high only while the sequencer is idle; a finished transaction
// waits in the response register, so the next request can be taken while
// rsp_ready is low.
`timescale 1ns / 1ps
`default_nettype none

module slot_pool_with_active_list
   import spal_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [REQ_W-1:0]    req_type,
   input  wire logic [SLOT_W-1:0]   req_slot,
   input  wire logic                req_any_slot,
   input  wire logic [HOUSE_W-1:0]  req_house,
   input  wire logic                req_any_house,
   input  wire logic [COUNT_W-1:0]  req_cursor,
   input  wire logic                req_from_start,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [SLOT_W-1:0]        rsp_result_slot,
   output logic [COUNT_W-1:0]       rsp_position,
   output logic [COUNT_W-1:0]       rsp_active_count
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC_SCAN,
      ST_FREE_CHECK,
      ST_FREE_SEARCH,
      ST_FREE_SHIFT,
      ST_FIND_SCAN,
      ST_RECOUNT_SCAN,
      ST_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [COUNT_W-1:0]       idx_ff, idx_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [POOL_SLOTS-1:0]    used_ff, used_in;
   logic [HOUSE_W-1:0]       house_ff [POOL_SLOTS];
   logic [SLOT_W-1:0]        list_ff [POOL_SLOTS];

   logic                     any_slot_ff, any_slot_in;
   logic                     any_house_ff, any_house_in;
   logic [HOUSE_W-1:0]       hreq_ff, hreq_in;
   logic [SLOT_W-1:0]        tgt_ff, tgt_in;

   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic [SLOT_W-1:0]        res_slot_ff, res_slot_in;
   logic [COUNT_W-1:0]       res_pos_ff, res_pos_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   // shared read and compare unit
   logic [COUNT_W-1:0]       idx_inc;
   logic [COUNT_W-1:0]       rd_addr;
   logic [SLOT_W-1:0]        list_rd;
   logic [HOUSE_W-1:0]       house_rd;
   logic                     used_rd;
   logic                     in_range;
   logic                     idx_last;

   logic                     list_we;
   logic [SLOT_W-1:0]        list_waddr;
   logic [SLOT_W-1:0]        list_wdata;
   logic                     house_we;

   assign idx_inc  = idx_ff + COUNT_W'(1);
   assign rd_addr  = (state_ff == ST_FREE_SHIFT) ? idx_inc : idx_ff;
   assign list_rd  = list_ff[rd_addr[SLOT_W-1:0]];
   assign house_rd = house_ff[list_rd];
   assign used_rd  = used_ff[idx_ff[SLOT_W-1:0]];
   assign in_range = idx_ff < count_ff;
   assign idx_last = idx_ff == COUNT_W'(POOL_SLOTS - 1);

   assign req_ready        = state_ff == ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_slot  = rsp_slot_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_active_count = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      any_slot_in   = any_slot_ff;
      any_house_in  = any_house_ff;
      hreq_in       = hreq_ff;
      tgt_in        = tgt_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_pos_in    = res_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      list_we       = 1'b0;
      list_waddr    = count_ff[SLOT_W-1:0];
      list_wdata    = idx_ff[SLOT_W-1:0];
      house_we      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               any_slot_in   = req_any_slot;
               any_house_in  = req_any_house;
               hreq_in       = req_house;
               tgt_in        = req_slot;
               res_status_in = STAT_OK;
               res_slot_in   = '0;
               res_pos_in    = '0;
               case (req_code_type'(req_type))
                  REQ_ALLOC: begin
                     idx_in   = req_any_slot ? '0 : COUNT_W'(req_slot);
                     state_in = ST_ALLOC_SCAN;
                  end
                  REQ_FREE: begin
                     idx_in   = COUNT_W'(req_slot);
                     state_in = ST_FREE_CHECK;
                  end
                  REQ_FIND: begin
                     // an out-of-list cursor parks the index past the end: a miss
                     if (req_from_start)
                        idx_in = '0;
                     else if (req_cursor >= count_ff)
                        idx_in = COUNT_W'(POOL_SLOTS);
                     else
                        idx_in = req_cursor + COUNT_W'(1);
                     state_in = ST_FIND_SCAN;
                  end
                  REQ_RECOUNT: begin
                     idx_in   = '0;
                     count_in = '0;
                     state_in = ST_RECOUNT_SCAN;
                  end
                  REQ_CLEAR: begin
                     used_in  = '0;
                     count_in = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_ALLOC_SCAN: begin
            if (!used_rd && count_ff < COUNT_W'(POOL_SLOTS)) begin
               used_in[idx_ff[SLOT_W-1:0]] = 1'b1;
               house_we    = 1'b1;
               list_we     = 1'b1;
               res_slot_in = idx_ff[SLOT_W-1:0];
               res_pos_in  = count_ff;
               count_in    = count_ff + COUNT_W'(1);
               state_in    = ST_DONE;
            end else if (!any_slot_ff || idx_last || !used_rd) begin
               res_status_in = STAT_BUSY;
               state_in      = ST_DONE;
            end else begin
               idx_in = idx_inc;
            end
         end

         ST_FREE_CHECK: begin
            if (!used_rd) begin
               res_status_in = STAT_NOT_USED;
               state_in      = ST_DONE;
            end else begin
               used_in[idx_ff[SLOT_W-1:0]] = 1'b0;
               res_slot_in = tgt_ff;
               idx_in      = '0;
               state_in    = ST_FREE_SEARCH;
            end
         end

         ST_FREE_SEARCH: begin
            if (!in_range)
               state_in = ST_DONE;
            else if (list_rd == tgt_ff)
               state_in = ST_FREE_SHIFT;
            else
               idx_in = idx_inc;
         end

         ST_FREE_SHIFT: begin
            // pull the next entry down one place, drop the tail at the end
            if (idx_inc < count_ff) begin
               list_we    = 1'b1;
               list_waddr = idx_ff[SLOT_W-1:0];
               list_wdata = list_rd;
               idx_in     = idx_inc;
            end else begin
               count_in = count_ff - COUNT_W'(1);
               state_in = ST_DONE;
            end
         end

         ST_FIND_SCAN: begin
            if (!in_range) begin
               res_status_in = STAT_NONE;
               res_slot_in   = '0;
               res_pos_in    = count_ff;
               state_in      = ST_DONE;
            end else if (any_house_ff || house_rd == hreq_ff) begin
               res_slot_in = list_rd;
               res_pos_in  = idx_ff;
               state_in    = ST_DONE;
            end else begin
               idx_in = idx_inc;
            end
         end

         ST_RECOUNT_SCAN: begin
            if (used_rd) begin
               list_we  = 1'b1;
               count_in = count_ff + COUNT_W'(1);
            end
            if (idx_last)
               state_in = ST_DONE;
            else
               idx_in = idx_inc;
         end

         ST_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      any_slot_ff   <= any_slot_in;
      any_house_ff  <= any_house_in;
      hreq_ff       <= hreq_in;
      tgt_ff        <= tgt_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
      if (list_we)
         list_ff[list_waddr] <= list_wdata;
      if (house_we)
         house_ff[idx_ff[SLOT_W-1:0]] <= hreq_ff;
   end

endmodule

`default_nettype wire

/* src/spal_checker.sv */
// Port-level checks for the slot pool and the bind that attaches them to
// slot_pool_with_active_list. Depends on spal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spal_checker
   import spal_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [SLOT_W-1:0]   rsp_result_slot,
   input wire logic [COUNT_W-1:0]  rsp_position,
   input wire logic [COUNT_W-1:0]  rsp_active_count
);

   // a stalled transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_result_slot) && $stable(rsp_position)
         && $stable(rsp_active_count))
      else $error("response changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_active_count <= COUNT_W'(POOL_SLOTS))
      else $error("active count beyond pool size");

   a_miss_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_NONE |->
         rsp_result_slot == '0 && rsp_position == rsp_active_count)
      else $error("find miss with wrong slot or position");

   a_fail_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_BUSY || rsp_status == STAT_NOT_USED) |->
         rsp_result_slot == '0 && rsp_position == '0)
      else $error("failed request reports a slot or position");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind slot_pool_with_active_list spal_checker u_spal_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_result_slot  (rsp_result_slot),
   .rsp_position     (rsp_position),
   .rsp_active_count (rsp_active_count)
);

`default_nettype wire
